### design/fractional_pll_setting_calc_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fractional PLL setting calculator
// Checks compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FRACTIONAL_PLL_SETTING_CALC_ASSERT_SVH
`define FRACTIONAL_PLL_SETTING_CALC_ASSERT_SVH
`ifndef SYNTHESIS
`define FPSC_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("check failed");
`define FPSC_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define FPSC_CHECK(label, cond)
`define FPSC_IMPLIES(label, ante, cons)
`endif
`endif

### design/fpsc_pkg.sv
// ---------------------------------------------------------------------------
// fpsc_pkg
// Types, constants and band table of the PLL setting calculator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package fpsc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TGT_W      = 32;
  localparam int REF_W      = 25;
  localparam int FVCO_W     = 34;
  localparam int DIVD_W     = FVCO_W + FRAC_BITS;
  localparam int REM_W      = REF_W;
  localparam int QUO_W      = 32;
  localparam int STEPS_A    = DIVD_W;
  localparam int STEPS_B    = FVCO_W;
  localparam int BAND_COUNT = 10;
  localparam logic [3:0] THREE_PHASE_BIT = 4'h8;
  localparam logic [REF_W-1:0] REF_RESET = REF_W'(28800000);

  localparam logic [31:0] BAND_LIMIT [BAND_COUNT] = '{
    32'd72400000, 32'd81200000, 32'd108300000, 32'd162500000, 32'd216600000,
    32'd325000000, 32'd350000000, 32'd432000000, 32'd667000000, 32'd1200000000
  };
  localparam logic [3:0] BAND_CODE [BAND_COUNT] = '{
    4'hF, 4'hE, 4'hD, 4'hC, 4'hB, 4'hA, 4'h9, 4'h3, 4'h2, 4'h1
  };
  localparam logic [5:0] BAND_DIV [BAND_COUNT] = '{
    6'd48, 6'd40, 6'd32, 6'd24, 6'd16, 6'd12, 6'd8, 6'd8, 6'd6, 6'd4
  };

  typedef struct packed {
    logic [5:0] r;
    logic [3:0] code;
    logic       tph;
  } band_t;

  typedef struct packed {
    logic [5:0]  r;
    logic [3:0]  code;
    logic        tph;
    logic        fzero;
    logic [7:0]  z8;
    logic [15:0] x;
    logic        err;
  } tag_t;

  typedef struct packed {
    logic              valid;
    logic [DIVD_W-1:0] divd;
    logic [REM_W-1:0]  divs;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
    tag_t              tag;
  } cell_t;

  function automatic band_t band_lookup(input logic [TGT_W-1:0] tgt);
    band_t b;
    logic  found;
    b     = '{r: 6'd2, code: 4'h0, tph: 1'b0};
    found = 1'b0;
    for (int i = 0; i < BAND_COUNT; i++) begin
      if (!found && tgt < BAND_LIMIT[i]) begin
        found  = 1'b1;
        b.r    = BAND_DIV[i];
        b.code = BAND_CODE[i];
        b.tph  = |(BAND_CODE[i] & THREE_PHASE_BIT);
      end
    end
    return b;
  endfunction

endpackage

### design/fpsc_in_if.sv
// ---------------------------------------------------------------------------
// fpsc_in_if
// Input stream channel: target LO frequency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fpsc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_lo_hz;
  modport source (output valid, output target_lo_hz, input ready);
  modport sink   (input valid, input target_lo_hz, output ready);
endinterface

### design/fpsc_out_if.sv
// ---------------------------------------------------------------------------
// fpsc_out_if
// Result stream channel: PLL settings and reached LO frequency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fpsc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] actual_lo_hz;
  logic [7:0]  pll_integer;
  logic [15:0] pll_fraction;
  logic [5:0]  out_divider;
  logic [3:0]  synth_select;
  logic        three_phase;
  logic        calc_error;
  modport source (output valid, output actual_lo_hz, output pll_integer,
                  output pll_fraction, output out_divider, output synth_select,
                  output three_phase, output calc_error, input ready);
  modport sink   (input valid, input actual_lo_hz, input pll_integer,
                  input pll_fraction, input out_divider, input synth_select,
                  input three_phase, input calc_error, output ready);
endinterface

### design/fractional_pll_setting_calc.sv
// ---------------------------------------------------------------------------
// fractional_pll_setting_calc
// Fractional-N PLL divider settings and reached LO frequency.
//
//   channel  dir  contents
//   in_ch    in   target_lo_hz
//   out_ch   out  actual_lo_hz, pll_integer, pll_fraction, out_divider,
//                 synth_select, three_phase, calc_error
//   cfg_*    in   ref_clock_hz write
//
// One item per cycle; stages: band stage, 50 division cells
// for (VCO << 16) / fref, multiply, recombine, 34 cells for VCO / R.
// Reset clears the reference clock to 28.8 MHz and empties the pipeline.
// The whole chain advances together; it halts only while a result waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fractional_pll_setting_calc_assert.svh"
module fractional_pll_setting_calc (
  input  logic                       clk,
  input  logic                       rst_n,
  fpsc_in_if.sink                    in_ch,
  fpsc_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [fpsc_pkg::REF_W-1:0] cfg_data
);

  logic                       en;
  logic [fpsc_pkg::REF_W-1:0] fref_r;
  fpsc_pkg::cell_t            front_q;
  fpsc_pkg::cell_t            recomb_q;
  fpsc_pkg::cell_t            a_q [fpsc_pkg::STEPS_A];
  fpsc_pkg::cell_t            b_q [fpsc_pkg::STEPS_B];
  fpsc_pkg::cell_t            last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fref_r <= fpsc_pkg::REF_RESET;
    end else if (cfg_we) begin
      fref_r <= cfg_data;
    end
  end

  assign last        = b_q[fpsc_pkg::STEPS_B-1];
  assign en          = !last.valid || out_ch.ready;
  assign in_ch.ready = en;

  fpsc_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
    .target(in_ch.target_lo_hz), .fref(fref_r), .cell_r(front_q)
  );

  for (genvar i = 0; i < fpsc_pkg::STEPS_A; i++) begin : g_a
    fpsc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .d((i == 0) ? front_q : a_q[(i == 0) ? 0 : i-1]), .cell_r(a_q[i])
    );
  end

  fpsc_recomb u_recomb (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d(a_q[fpsc_pkg::STEPS_A-1]), .cell_r(recomb_q)
  );

  for (genvar i = 0; i < fpsc_pkg::STEPS_B; i++) begin : g_b
    fpsc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .d((i == 0) ? recomb_q : b_q[(i == 0) ? 0 : i-1]), .cell_r(b_q[i])
    );
  end

  assign out_ch.valid        = last.valid;
  assign out_ch.actual_lo_hz = last.tag.err ? 32'd0 : last.quo;
  assign out_ch.pll_integer  = last.tag.z8;
  assign out_ch.pll_fraction = last.tag.x;
  assign out_ch.out_divider  = last.tag.r;
  assign out_ch.synth_select = last.tag.code;
  assign out_ch.three_phase  = last.tag.tph;
  assign out_ch.calc_error   = last.tag.err;

  `FPSC_IMPLIES(a_err_zero, out_ch.valid && out_ch.calc_error, out_ch.actual_lo_hz == 32'd0)
  `FPSC_IMPLIES(a_tph_code, out_ch.valid, out_ch.three_phase == out_ch.synth_select[3])
  `FPSC_IMPLIES(a_noband, out_ch.valid, (out_ch.synth_select == 4'h0) == (out_ch.out_divider == 6'd2))

endmodule

### design/fpsc_div_cell.sv
// ---------------------------------------------------------------------------
// fpsc_div_cell
// One restoring-division step: one quotient bit, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpsc_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fpsc_pkg::cell_t d,
  output fpsc_pkg::cell_t cell_r
);

  logic [fpsc_pkg::REM_W:0] t;
  logic [fpsc_pkg::REM_W:0] diff;
  logic                     ge;
  fpsc_pkg::cell_t          cell_nxt;

  always_comb begin
    t        = {d.rem, d.divd[fpsc_pkg::DIVD_W-1]};
    diff     = t - {1'b0, d.divs};
    ge       = t >= {1'b0, d.divs};
    cell_nxt = d;
    cell_nxt.divd = {d.divd[fpsc_pkg::DIVD_W-2:0], 1'b0};
    cell_nxt.rem  = ge ? diff[fpsc_pkg::REM_W-1:0] : t[fpsc_pkg::REM_W-1:0];
    cell_nxt.quo  = {d.quo[fpsc_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

endmodule

### design/fpsc_front.sv
// ---------------------------------------------------------------------------
// fpsc_front
// Band lookup and VCO frequency; loads the first division chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpsc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [fpsc_pkg::TGT_W-1:0]   target,
  input  logic [fpsc_pkg::REF_W-1:0]   fref,
  output fpsc_pkg::cell_t              cell_r
);

  localparam int PROD_W = fpsc_pkg::TGT_W + 6;

  fpsc_pkg::band_t          band;
  logic [PROD_W-1:0]        prod;
  fpsc_pkg::cell_t          cell_nxt;

  always_comb begin
    band     = fpsc_pkg::band_lookup(target);
    prod     = PROD_W'(target) * PROD_W'(band.r);
    cell_nxt = '0;
    cell_nxt.valid     = in_valid;
    cell_nxt.divd      = {prod[fpsc_pkg::FVCO_W-1:0], {fpsc_pkg::FRAC_BITS{1'b0}}};
    cell_nxt.divs      = fref;
    cell_nxt.tag.r     = band.r;
    cell_nxt.tag.code  = band.code;
    cell_nxt.tag.tph   = band.tph;
    cell_nxt.tag.fzero = (fref == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

endmodule

### design/fpsc_recomb.sv
// ---------------------------------------------------------------------------
// fpsc_recomb
// Rebuilds the VCO frequency from Z and X; loads the second chain (/ R).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpsc_recomb (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fpsc_pkg::cell_t d,
  output fpsc_pkg::cell_t cell_r
);

  localparam int P1_W = fpsc_pkg::REF_W + 8;
  localparam int P2_W = fpsc_pkg::REF_W + fpsc_pkg::FRAC_BITS;

  logic                        mvalid_r;
  fpsc_pkg::tag_t              mtag_r;
  fpsc_pkg::tag_t              mtag_nxt;
  logic [P1_W-1:0]             p1_r;
  logic [P2_W-1:0]             p2_r;
  logic [fpsc_pkg::FVCO_W-1:0] vco;
  fpsc_pkg::cell_t             cell_nxt;

  always_comb begin
    mtag_nxt    = d.tag;
    mtag_nxt.z8 = d.tag.fzero ? 8'd0 : d.quo[fpsc_pkg::FRAC_BITS+7:fpsc_pkg::FRAC_BITS];
    mtag_nxt.x  = d.tag.fzero ? 16'd0 : d.quo[fpsc_pkg::FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvalid_r <= 1'b0;
    end else if (en) begin
      mvalid_r <= d.valid;
      mtag_r   <= mtag_nxt;
      p1_r     <= P1_W'(d.divs) * P1_W'(mtag_nxt.z8);
      p2_r     <= P2_W'(d.divs) * P2_W'(mtag_nxt.x);
    end
  end

  always_comb begin
    vco = fpsc_pkg::FVCO_W'(p1_r) +
          fpsc_pkg::FVCO_W'(p2_r[P2_W-1:fpsc_pkg::FRAC_BITS]);
    cell_nxt = '0;
    cell_nxt.valid   = mvalid_r;
    cell_nxt.divd    = {vco, {(fpsc_pkg::DIVD_W-fpsc_pkg::FVCO_W){1'b0}}};
    cell_nxt.divs    = fpsc_pkg::REM_W'(mtag_r.r);
    cell_nxt.tag     = mtag_r;
    cell_nxt.tag.err = (vco == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

endmodule
